FILE: design/tlr_pkg.sv
// Shared types and constants for the thick line rasterizer.
// Holds the command and status encodings passed between the sequencer and
// its disc scan and line walk units. No dependencies.
package tlr_pkg;

	// Fixed field widths of the transfer payload.
	localparam int COLOUR_BITS    = 64;
	localparam int RADIUS_IN_BITS = 6;

	// Meaning of the action field.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// Commands to the disc offset scanner.
	typedef enum logic [1:0] {
		SCAN_HOLD,
		SCAN_LOAD,
		SCAN_RESTART,
		SCAN_ADVANCE
	} scan_cmd_t;

	// Status of the disc offset scanner.
	typedef struct packed {
		logic kept;   // current offset lies inside the disc
		logic wrap;   // advancing from the current offset finishes the disc
	} scan_stat_t;

	// Commands to the line walker.
	typedef enum logic [1:0] {
		WALK_HOLD,
		WALK_LOAD,
		WALK_STEP
	} walk_cmd_t;

endpackage

FILE: design/thick_line_rasterizer.sv
// Thick line rasterizer. A load transfer (action 0) latches two endpoints, a
// brush radius and a colour; it gives no result. Each step transfer (action 1)
// gives one pixel write of the Bresenham line stamped with a filled disc at
// every centre, or an all-zero result in the next cycle when no line is active.
// A step occupies the block while the scanner tests each following disc offset,
// up to and including the next offset inside the disc or the end of the disc;
// the scanner tests one offset per cycle. The last pixel of a disc needs no
// scan. in_stall is high while that scan runs and while a finished result
// waits on out_stall.
// Depends on tlr_pkg, tlr_disc_scan and tlr_line_walk.
module thick_line_rasterizer import tlr_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int RADIUS_MAX = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [RADIUS_IN_BITS-1:0]    brush_radius,
	input  logic [COLOUR_BITS-1:0]       colour,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         pixel_valid,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic [COLOUR_BITS-1:0]       pixel_colour,
	output logic                         last_pixel
);

	localparam int CB  = COORD_BITS;
	localparam int RBC = $clog2(RADIUS_MAX + 1);
	localparam int RB  = (RBC < 1) ? 1 : RBC;
	localparam int OB  = RB + 2;
	localparam int SW  = ((CB + 1 > OB) ? CB + 1 : OB) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READY,
		ST_SEARCH
	} state_t;

	state_t                 state_q;
	logic                   out_valid_q;
	logic                   pix_valid_q;
	logic signed [CB:0]     pix_x_q;
	logic signed [CB:0]     pix_y_q;
	logic [COLOUR_BITS-1:0] pix_colour_q;
	logic                   last_q;
	logic [COLOUR_BITS-1:0] colour_q;

	scan_cmd_t            scan_cmd;
	scan_stat_t           scan_stat;
	logic signed [OB-1:0] row;
	logic signed [OB-1:0] col;
	logic [RB-1:0]        radius_sat;
	walk_cmd_t            walk_cmd;
	logic signed [CB:0]   centre_x;
	logic signed [CB:0]   centre_y;
	logic                 at_end;

	logic                 accept;
	logic                 is_load;
	logic                 is_step;
	logic                 run;
	logic                 found;
	logic                 disc_end;
	logic                 set_out;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;

	// Radius saturation at load.
	assign radius_sat = (int'(brush_radius) > RADIUS_MAX) ? RB'(RADIUS_MAX) : RB'(brush_radius);

	// Handshake and sequencing decisions.
	assign in_stall = (state_q == ST_SEARCH) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign is_load  = accept && (action == ACT_LOAD);
	assign is_step  = accept && (action == ACT_STEP);
	assign run      = (is_step && state_q == ST_READY) || (state_q == ST_SEARCH);
	assign found    = (state_q == ST_SEARCH) && scan_stat.kept;
	assign disc_end = run && !found && scan_stat.wrap;
	assign set_out  = (is_step && state_q == ST_IDLE) || found || disc_end;

	// Commands to the scan and walk units.
	always_comb begin
		scan_cmd = SCAN_HOLD;
		walk_cmd = WALK_HOLD;
		if (is_load) begin
			scan_cmd = SCAN_LOAD;
			walk_cmd = WALK_LOAD;
		end else if (disc_end) begin
			if (!at_end) begin
				scan_cmd = SCAN_RESTART;
				walk_cmd = WALK_STEP;
			end
		end else if (run && !found) begin
			scan_cmd = SCAN_ADVANCE;
		end
	end

	// Pixel position of the current centre and offset.
	assign sum_x = SW'(centre_x) + SW'(col);
	assign sum_y = SW'(centre_y) + SW'(row);

	tlr_disc_scan #(
		.RB(RB)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scan_cmd),
		.radius (radius_sat),
		.row    (row),
		.col    (col),
		.stat   (scan_stat)
	);

	tlr_line_walk #(
		.CB(CB)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (walk_cmd),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.at_end   (at_end)
	);

	// Sequencer state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			pix_valid_q  <= 1'b0;
			pix_x_q      <= '0;
			pix_y_q      <= '0;
			pix_colour_q <= '0;
			last_q       <= 1'b0;
			colour_q     <= '0;
		end else begin
			// A new result is raised; a transferred one is dropped.
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (is_load) begin
				colour_q <= colour;
				state_q  <= ST_READY;
			end else if (is_step && state_q == ST_IDLE) begin
				pix_valid_q  <= 1'b0;
				pix_x_q      <= '0;
				pix_y_q      <= '0;
				pix_colour_q <= '0;
				last_q       <= 1'b0;
			end else if (run) begin
				if (is_step) begin
					pix_valid_q  <= 1'b1;
					pix_x_q      <= sum_x[CB:0];
					pix_y_q      <= sum_y[CB:0];
					pix_colour_q <= colour_q;
				end
				if (found) begin
					last_q  <= 1'b0;
					state_q <= ST_READY;
				end else if (disc_end) begin
					last_q  <= at_end;
					state_q <= at_end ? ST_IDLE : ST_READY;
				end else begin
					state_q <= ST_SEARCH;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_valid  = pix_valid_q;
	assign pixel_x      = pix_x_q;
	assign pixel_y      = pix_y_q;
	assign pixel_colour = pix_colour_q;
	assign last_pixel   = last_q;

endmodule

FILE: design/tlr_disc_scan.sv
// Disc offset scanner: holds the brush radius and the current row and column
// offset, advances one offset per command and tests it against the disc.
// Depends on tlr_pkg.
module tlr_disc_scan import tlr_pkg::*; #(
	parameter int RB = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scan_cmd_t            cmd,
	input  logic [RB-1:0]        radius,
	output logic signed [RB+1:0] row,
	output logic signed [RB+1:0] col,
	output scan_stat_t           stat
);

	localparam int OB = RB + 2;
	localparam int SB = 2 * OB + 1;

	logic signed [OB-1:0] row_q;
	logic signed [OB-1:0] col_q;
	logic [RB-1:0]        rad_q;
	logic [2*RB-1:0]      rsq_q;

	logic signed [OB-1:0]   rad_s;
	logic signed [OB-1:0]   col_inc;
	logic signed [OB-1:0]   row_nx;
	logic signed [OB-1:0]   col_nx;
	logic signed [2*OB-1:0] row_sq;
	logic signed [2*OB-1:0] col_sq;
	logic [SB-1:0]          norm_sq;

	assign rad_s = signed'({2'b00, rad_q});

	// Next offset in scan order: column up, then wrap to the next row down.
	always_comb begin
		col_inc = col_q + OB'(1);
		row_nx  = row_q;
		col_nx  = col_inc;
		if (col_inc > rad_s) begin
			col_nx = -rad_s;
			row_nx = row_q - OB'(1);
		end
	end

	// Inside test of the current offset.
	assign row_sq  = row_q * row_q;
	assign col_sq  = col_q * col_q;
	assign norm_sq = SB'(unsigned'(row_sq)) + SB'(unsigned'(col_sq));

	assign stat.kept = (norm_sq <= SB'(rsq_q));
	assign stat.wrap = (row_nx < -rad_s);
	assign row       = row_q;
	assign col       = col_q;

	// Offset and radius registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rad_q <= '0;
			rsq_q <= '0;
		end else begin
			case (cmd)
				SCAN_LOAD: begin
					rad_q <= radius;
					rsq_q <= (2*RB)'(radius * radius);
					row_q <= signed'({2'b00, radius});
					col_q <= '0;
				end
				SCAN_RESTART: begin
					row_q <= rad_s;
					col_q <= '0;
				end
				SCAN_ADVANCE: begin
					row_q <= row_nx;
					col_q <= col_nx;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/tlr_line_walk.sv
// Line walker: sets up the Bresenham terms on load and moves the centre one
// step along the major axis per command. Depends on tlr_pkg.
module tlr_line_walk import tlr_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  walk_cmd_t            cmd,
	input  logic signed [CB-1:0] start_x,
	input  logic signed [CB-1:0] start_y,
	input  logic signed [CB-1:0] end_x,
	input  logic signed [CB-1:0] end_y,
	output logic signed [CB:0]   centre_x,
	output logic signed [CB:0]   centre_y,
	output logic                 at_end
);

	localparam int EB = CB + 4;

	logic signed [CB:0]   cx_q;
	logic signed [CB:0]   cy_q;
	logic signed [CB-1:0] end_q;
	logic signed [EB-1:0] err_q;
	logic [CB:0]          tmaj_q;
	logic [CB:0]          tmin_q;
	logic                 neg_q;
	logic                 steep_q;

	logic signed [CB:0]   dx;
	logic signed [CB:0]   dy;
	logic [CB-1:0]        adx;
	logic [CB-1:0]        ady;
	logic                 steep_ld;
	logic                 swap_x;
	logic                 swap_y;
	logic signed [CB-1:0] ld_cx;
	logic signed [CB-1:0] ld_cy;
	logic signed [CB-1:0] ld_end;
	logic                 ld_neg;
	logic signed [EB-1:0] ld_err;
	logic signed [EB-1:0] err_add;
	logic signed [EB-1:0] err_nx;
	logic signed [CB:0]   minor_d;
	logic signed [CB:0]   cx_nx;
	logic signed [CB:0]   cy_nx;

	// Load setup: deltas, orientation and the start at the lower end.
	always_comb begin
		dx       = (CB+1)'(end_x) - (CB+1)'(start_x);
		dy       = (CB+1)'(end_y) - (CB+1)'(start_y);
		adx      = dx[CB] ? CB'(-dx) : CB'(dx);
		ady      = dy[CB] ? CB'(-dy) : CB'(dy);
		steep_ld = (ady != '0) && (ady >= adx);
		swap_x   = end_x < start_x;
		swap_y   = end_y < start_y;
		if (steep_ld) begin
			ld_cx  = swap_y ? end_x : start_x;
			ld_cy  = swap_y ? end_y : start_y;
			ld_end = swap_y ? start_y : end_y;
			ld_neg = (swap_y ? start_x : end_x) < ld_cx;
			ld_err = signed'(EB'({adx, 1'b0})) - signed'(EB'(ady));
		end else begin
			ld_cx  = swap_x ? end_x : start_x;
			ld_cy  = swap_x ? end_y : start_y;
			ld_end = swap_x ? start_x : end_x;
			ld_neg = (swap_x ? start_y : end_y) < ld_cy;
			ld_err = signed'(EB'({ady, 1'b0})) - signed'(EB'(adx));
		end
	end

	// One Bresenham step: accumulate, decide the minor step, advance major.
	always_comb begin
		err_add = err_q + signed'(EB'(tmin_q));
		err_nx  = err_add;
		minor_d = '0;
		if (!err_add[EB-1]) begin
			minor_d = neg_q ? -(CB+1)'(1) : (CB+1)'(1);
			err_nx  = err_add - signed'(EB'(tmaj_q));
		end
		if (steep_q) begin
			cx_nx = cx_q + minor_d;
			cy_nx = cy_q + (CB+1)'(1);
		end else begin
			cx_nx = cx_q + (CB+1)'(1);
			cy_nx = cy_q + minor_d;
		end
	end

	assign at_end   = (steep_q ? cy_q : cx_q) >= (CB+1)'(end_q);
	assign centre_x = cx_q;
	assign centre_y = cy_q;

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			end_q   <= '0;
			err_q   <= '0;
			tmaj_q  <= '0;
			tmin_q  <= '0;
			neg_q   <= 1'b0;
			steep_q <= 1'b0;
		end else begin
			case (cmd)
				WALK_LOAD: begin
					cx_q    <= (CB+1)'(ld_cx);
					cy_q    <= (CB+1)'(ld_cy);
					end_q   <= ld_end;
					err_q   <= ld_err;
					tmaj_q  <= steep_ld ? {ady, 1'b0} : {adx, 1'b0};
					tmin_q  <= steep_ld ? {adx, 1'b0} : {ady, 1'b0};
					neg_q   <= ld_neg;
					steep_q <= steep_ld;
				end
				WALK_STEP: begin
					cx_q  <= cx_nx;
					cy_q  <= cy_nx;
					err_q <= err_nx;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/tlr_checker.sv
// Port-level checker for the thick line rasterizer, bound to the top level.
// Depends on tlr_pkg and thick_line_rasterizer.
module tlr_checker import tlr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         action,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         pixel_valid,
	input logic signed [COORD_BITS:0]   pixel_x,
	input logic signed [COORD_BITS:0]   pixel_y,
	input logic [COLOUR_BITS-1:0]       pixel_colour,
	input logic                         last_pixel
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_valid) && $stable(pixel_x)
			&& $stable(pixel_y) && $stable(pixel_colour) && $stable(last_pixel))
		else $error("result changed while stalled");

	// The end of a line is only marked on a real pixel write.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_valid)
		else $error("last_pixel without pixel_valid");

	// An idle result carries all-zero fields.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0
			&& pixel_colour == '0 && !last_pixel)
		else $error("idle result with nonzero fields");

	// A load gives no result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_LOAD && !(out_valid && out_stall)
			|=> !out_valid)
		else $error("result after a load transfer");

endmodule

bind thick_line_rasterizer tlr_checker #(
	.COORD_BITS(COORD_BITS)
) u_tlr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.action       (action),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_valid  (pixel_valid),
	.pixel_x      (pixel_x),
	.pixel_y      (pixel_y),
	.pixel_colour (pixel_colour),
	.last_pixel   (last_pixel)
);

FILE: dv/tb.sv
// Self-checking testbench for the thick line rasterizer.
// Drives load and step transfers, predicts every pixel write in a local line and disc model,
// and compares each write field by field. Depends on tlr_pkg and thick_line_rasterizer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlr_pkg::*;

	localparam int COORD_BITS   = 16;
	localparam int RADIUS_MAX   = 63;
	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 2 * RADIUS_MAX + 16;
	localparam int CYCLE_LIMIT  = 2000000;

	// One input transfer.
	typedef struct {
		logic                         action;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
		logic [RADIUS_IN_BITS-1:0]    radius;
		logic [COLOUR_BITS-1:0]       colour;
	} stim_t;

	// One pixel write.
	typedef struct {
		logic                       pv;
		logic signed [COORD_BITS:0] x;
		logic signed [COORD_BITS:0] y;
		logic [COLOUR_BITS-1:0]     colour;
		logic                       last;
	} pixel_t;

	// One row of the directed table.
	typedef struct {
		stim_t  s;
		bit     typed;
		pixel_t want;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [RADIUS_IN_BITS-1:0]    brush_radius;
	logic [COLOUR_BITS-1:0]       colour;
	logic                         out_valid;
	logic                         out_stall;
	logic                         pixel_valid;
	logic signed [COORD_BITS:0]   pixel_x;
	logic signed [COORD_BITS:0]   pixel_y;
	logic [COLOUR_BITS-1:0]       pixel_colour;
	logic                         last_pixel;

	thick_line_rasterizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.brush_radius (brush_radius),
		.colour       (colour),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_valid  (pixel_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_colour (pixel_colour),
		.last_pixel   (last_pixel)
	);

	// Line walker and disc stamp state of the local model.
	int              pen_x, pen_y, major_last, slope_err, major_twice, minor_twice;
	bit              minor_down, steep, drawing;
	int              disc_row, disc_col, brush_r, brush_r_sq;
	logic [63:0]     ink;

	pixel_t          pending_pixels[$];
	dir_row_t        directed_rows[$];
	int              mismatches;
	int              items_sent;
	int              cycles;
	int              send_idle_pct, recv_idle_pct;
	int              hold_requests, holds_served, hold_left;

	// 20 ns clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Moves to the next offset inside the disc; returns 0 once the disc is finished.
	function automatic bit next_disc_offset();
		bit done, kept;
		done = 1'b0;
		kept = 1'b0;
		while (!done) begin
			disc_col++;
			if (disc_col > brush_r) begin
				disc_col = -brush_r;
				disc_row--;
				if (disc_row < -brush_r)
					done = 1'b1;
			end
			if (!done && disc_row * disc_row + disc_col * disc_col <= brush_r_sq) begin
				kept = 1'b1;
				done = 1'b1;
			end
		end
		return kept;
	endfunction

	// Predicts the pixel write, if any, caused by one accepted transfer.
	function automatic void rasterize_item(input stim_t s, output bit gives, output pixel_t p);
		int x1, y1, x2, y2, mx, my, sum, major;
		bit swap;
		p = '{pv: 1'b0, x: '0, y: '0, colour: '0, last: 1'b0};
		gives = 1'b0;
		if (s.action == ACT_LOAD) begin
			x1 = s.sx;
			y1 = s.sy;
			x2 = s.ex;
			y2 = s.ey;
			mx = 2 * ((x2 > x1) ? x2 - x1 : x1 - x2);
			my = 2 * ((y2 > y1) ? y2 - y1 : y1 - y2);
			steep = (my != 0) && (my >= mx);
			if (steep) begin
				swap = y2 < y1;
				pen_x = swap ? x2 : x1;
				pen_y = swap ? y2 : y1;
				major_last = swap ? y1 : y2;
				minor_down = (swap ? x1 : x2) < pen_x;
				major_twice = my;
				minor_twice = mx;
				slope_err = mx - my / 2;
			end else begin
				swap = x2 < x1;
				pen_x = swap ? x2 : x1;
				pen_y = swap ? y2 : y1;
				major_last = swap ? x1 : x2;
				minor_down = (swap ? y1 : y2) < pen_y;
				major_twice = mx;
				minor_twice = my;
				slope_err = my - mx / 2;
			end
			brush_r = (s.radius > RADIUS_MAX) ? RADIUS_MAX : s.radius;
			brush_r_sq = brush_r * brush_r;
			ink = s.colour;
			disc_row = brush_r;
			disc_col = 0;
			drawing = 1'b1;
			return;
		end

		gives = 1'b1;
		if (!drawing)
			return;

		// Emit the current disc pixel, then advance the disc and, at its end, the line.
		p.pv = 1'b1;
		sum = pen_x + disc_col;
		p.x = sum[COORD_BITS:0];
		sum = pen_y + disc_row;
		p.y = sum[COORD_BITS:0];
		p.colour = ink;
		if (!next_disc_offset()) begin
			major = steep ? pen_y : pen_x;
			if (major >= major_last) begin
				drawing = 1'b0;
				p.last = 1'b1;
			end else begin
				slope_err += minor_twice;
				if (slope_err >= 0) begin
					if (steep)
						pen_x += minor_down ? -1 : 1;
					else
						pen_y += minor_down ? -1 : 1;
					slope_err -= major_twice;
				end
				if (steep)
					pen_y++;
				else
					pen_x++;
				disc_row = brush_r;
				disc_col = 0;
			end
		end
	endfunction

	// Directed table helpers.
	function automatic dir_row_t load_row(int sx, int sy, int ex, int ey, int r,
			logic [63:0] c);
		dir_row_t d;
		d.s.action = ACT_LOAD;
		d.s.sx = sx[15:0];
		d.s.sy = sy[15:0];
		d.s.ex = ex[15:0];
		d.s.ey = ey[15:0];
		d.s.radius = r[5:0];
		d.s.colour = c;
		d.typed = 1'b0;
		d.want = '{pv: 1'b0, x: '0, y: '0, colour: '0, last: 1'b0};
		return d;
	endfunction

	function automatic dir_row_t step_row();
		dir_row_t d;
		d = load_row(0, 0, 0, 0, 0, 64'h0);
		d.s.action = ACT_STEP;
		return d;
	endfunction

	function automatic dir_row_t step_row_want(bit pv, int x, int y, logic [63:0] c, bit last);
		dir_row_t d;
		d = step_row();
		d.typed = 1'b1;
		d.want.pv = pv;
		d.want.x = x[16:0];
		d.want.y = y[16:0];
		d.want.colour = c;
		d.want.last = last;
		return d;
	endfunction

	function automatic stim_t random_fields();
		stim_t s;
		s.action = 1'($urandom_range(1));
		s.sx = COORD_BITS'($urandom);
		s.sy = COORD_BITS'($urandom);
		s.ex = COORD_BITS'($urandom);
		s.ey = COORD_BITS'($urandom);
		s.radius = RADIUS_IN_BITS'($urandom_range(63));
		s.colour = {$urandom, $urandom};
		return s;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offers one transfer, starting at a falling edge, and returns at the falling edge
	// after it is accepted. The prediction is made at the accepting edge.
	task automatic offer(input stim_t s, input bit typed, input pixel_t want);
		bit     gives;
		pixel_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= s.action;
		start_x      <= s.sx;
		start_y      <= s.sy;
		end_x        <= s.ex;
		end_y        <= s.ey;
		brush_radius <= s.radius;
		colour       <= s.colour;
		do
			@(posedge clk);
		while (in_stall);
		rasterize_item(s, gives, p);
		if (gives)
			pending_pixels.push_back(typed ? want : p);
		items_sent++;
		@(negedge clk);
	endtask

	// The sender pauses until every predicted write has arrived.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare every accepted pixel write with the oldest prediction.
	always @(posedge clk) begin : check_pixels
		pixel_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel write transfer with no expectation waiting");
				mismatches++;
			end else begin
				w = pending_pixels.pop_front();
				check_field("pixel_valid", 64'(w.pv), 64'(pixel_valid));
				check_field("pixel_x", 64'(w.x), 64'(pixel_x));
				check_field("pixel_y", 64'(w.y), 64'(pixel_y));
				check_field("pixel_colour", w.colour, pixel_colour);
				check_field("last_pixel", 64'(w.last), 64'(last_pixel));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		stim_t  s;
		pixel_t none;
		int     kind, dx, dy, n, k, random_base;
		bit     finish;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_LOAD;
		start_x       = '0;
		start_y       = '0;
		end_x         = '0;
		end_y         = '0;
		brush_radius  = '0;
		colour        = '0;
		items_sent    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		drawing       = 1'b0;
		steep         = 1'b0;
		minor_down    = 1'b0;
		pen_x = 0; pen_y = 0; major_last = 0; slope_err = 0;
		major_twice = 0; minor_twice = 0;
		disc_row = 0; disc_col = 0; brush_r = 0; brush_r_sq = 0;
		ink = '0;
		none = '{pv: 1'b0, x: '0, y: '0, colour: '0, last: 1'b0};

		// Step while idle, single points, extreme corners and colours, flat, upright
		// and steep lines with the minor axis falling, and loads that cut a line short.
		directed_rows.push_back(step_row_want(0, 0, 0, 64'h0, 0));
		directed_rows.push_back(load_row(5, -7, 5, -7, 0, 64'h0123_4567_89AB_CDEF));
		directed_rows.push_back(step_row_want(1, 5, -7, 64'h0123_4567_89AB_CDEF, 1));
		directed_rows.push_back(step_row_want(0, 0, 0, 64'h0, 0));
		directed_rows.push_back(load_row(32767, 32767, 32767, 32767, 63, '1));
		directed_rows.push_back(step_row_want(1, 32767, 32830, '1, 0));
		directed_rows.push_back(step_row());
		directed_rows.push_back(load_row(-32768, -32768, 32767, 32767, 1, 64'h0));
		directed_rows.push_back(step_row_want(1, -32768, -32767, 64'h0, 0));
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());
		directed_rows.push_back(load_row(-32768, 32767, 32767, -32768, 0, {16{4'h5}}));
		directed_rows.push_back(step_row_want(1, 32767, -32768, {16{4'h5}}, 0));
		directed_rows.push_back(step_row());
		directed_rows.push_back(load_row(10, 3, -2, 3, 0, {16{4'hA}}));
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());
		directed_rows.push_back(load_row(0, -1, 0, 2, 2, 64'h8000_0000_0000_0001));
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());
		directed_rows.push_back(load_row(4, 0, 1, 9, 0, 64'hDEAD_BEEF_0BAD_F00D));
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());
		directed_rows.push_back(step_row());

		// Reset.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);
		pause_until_drained();

		// Random part in three idling phases; the last one starts with a long hold-off.
		random_base = items_sent;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_requests++;
				end
			endcase
			while (items_sent < random_base + (ph + 1) * RANDOM_ITEMS / 3) begin
				kind = $urandom_range(99);
				s = random_fields();
				if (kind < 15) begin
					// Noise: any action with any content.
					offer(s, 1'b0, none);
				end else begin
					// A load followed by steps; some short lines are walked to the end.
					s.action = ACT_LOAD;
					finish = (kind < 55);
					if (finish || $urandom_range(1)) begin
						dx = int'($urandom_range(12)) - 6;
						dy = int'($urandom_range(12)) - 6;
						s.ex = s.sx + dx[15:0];
						s.ey = s.sy + dy[15:0];
					end
					if (finish)
						s.radius = RADIUS_IN_BITS'($urandom_range(2));
					else if ($urandom_range(9) != 0)
						s.radius = RADIUS_IN_BITS'($urandom_range(4));
					offer(s, 1'b0, none);
					n = finish ? 150 : $urandom_range(40, 1);
					for (k = 0; k < n && (!finish || drawing); k++) begin
						s = random_fields();
						s.action = ACT_STEP;
						offer(s, 1'b0, none);
					end
					if (finish) begin
						n = $urandom_range(2);
						for (k = 0; k < n; k++) begin
							s = random_fields();
							s.action = ACT_STEP;
							offer(s, 1'b0, none);
						end
					end
				end
			end
			pause_until_drained();
		end

		// Wind down and report.
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
